FILE: rtl/bmp_8bit_stream_parser_top_defines.svh
// Assertion macros shared by the bitmap stream parser.
`ifndef BMP_8BIT_STREAM_PARSER_TOP_DEFINES_SVH
`define BMP_8BIT_STREAM_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BMP8_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BMP8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bmp8_pkg.sv
// Types and constants of the 8-bit palettised bitmap stream parser.
`timescale 1ns / 1ps

package bmp8_pkg;

	typedef enum logic [4:0] {
		PH_SIG  = 5'b00001,
		PH_HDR  = 5'b00010,
		PH_PAL  = 5'b00100,
		PH_PIX  = 5'b01000,
		PH_IDLE = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PALETTE = 2'd1,
		KIND_PIXEL   = 2'd2,
		KIND_BAD_SIG = 2'd3
	} kind_t;

	localparam logic [7:0] SIG_FIRST  = 8'h42;
	localparam logic [7:0] SIG_SECOND = 8'h4D;

	localparam logic [5:0] HDR_WIDTH_LO  = 6'd16;
	localparam logic [5:0] HDR_WIDTH_HI  = 6'd17;
	localparam logic [5:0] HDR_HEIGHT_LO = 6'd20;
	localparam logic [5:0] HDR_HEIGHT_HI = 6'd21;
	localparam logic [5:0] HDR_LAST      = 6'd51;

	localparam logic [1:0] CH_BLUE     = 2'd0;
	localparam logic [1:0] CH_GREEN    = 2'd1;
	localparam logic [1:0] CH_RED      = 2'd2;
	localparam logic [1:0] CH_RESERVED = 2'd3;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [7:0]  palette_index;
		logic [5:0]  red_level;
		logic [5:0]  green_level;
		logic [5:0]  blue_level;
		logic [15:0] pixel_address;
		logic [7:0]  pixel_value;
		logic        last;
	} result_t;

endpackage

FILE: rtl/bmp8_in_if.sv
// Input channel carrying one file byte per beat.
`timescale 1ns / 1ps

interface bmp8_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_value;
	logic       start_of_file;

	modport source (output valid, byte_value, start_of_file, input ready);
	modport sink (input valid, byte_value, start_of_file, output ready);
endinterface

FILE: rtl/bmp8_out_if.sv
// Result channel carrying one decoded result per beat.
`timescale 1ns / 1ps

interface bmp8_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic [7:0]  palette_index;
	logic [5:0]  red_level;
	logic [5:0]  green_level;
	logic [5:0]  blue_level;
	logic [15:0] pixel_address;
	logic [7:0]  pixel_value;
	logic        last;

	modport source (output valid, kind, image_width, image_height, palette_index,
		red_level, green_level, blue_level, pixel_address, pixel_value, last,
		input ready);
	modport sink (input valid, kind, image_width, image_height, palette_index,
		red_level, green_level, blue_level, pixel_address, pixel_value, last,
		output ready);
endinterface

FILE: rtl/bmp_8bit_stream_parser_top.sv
// Top level of the 8-bit palettised bitmap stream parser.
// The parser takes one file byte per beat and can accept a beat in every cycle: each byte
// passes through the state update into a result register, so a result appears in the cycle
// after its byte is accepted. Input is stalled only while the result register is full
// and its beat is not being taken. A byte with start_of_file set restarts the parse. The
// signature, header, palette and pixel sections are tracked by a small phase machine; pixel
// store addresses are formed by adding the column to a row base that is set by a single
// multiply when the palette ends and then stepped down by the width once per row.
`timescale 1ns / 1ps
`include "bmp_8bit_stream_parser_top_defines.svh"

module bmp_8bit_stream_parser_top
	import bmp8_pkg::*;
#(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	bmp8_in_if.sink           byte_in,
	bmp8_out_if.source        result_out
);

	localparam int ENTRY_W = $clog2(PALETTE_ENTRIES + 1);

	phase_t               phase_q;
	logic [5:0]           header_count_q;
	logic [15:0]          width_q;
	logic [15:0]          height_q;
	logic [ENTRY_W-1:0]   entry_count_q;
	logic [1:0]           channel_q;
	logic [5:0]           blue_hold_q;
	logic [5:0]           green_hold_q;
	logic [15:0]          column_q;
	logic [15:0]          row_base_q;
	logic [15:0]          rows_left_q;
	logic                 palette_enable_q;
	logic                 out_valid_q;
	result_t              res_q;

	phase_t               ph;
	logic [5:0]           hc;
	logic [15:0]          wd;
	logic [15:0]          ht;
	logic [ENTRY_W-1:0]   ec;
	logic [1:0]           cc;
	logic [5:0]           bh;
	logic [5:0]           gh;
	logic [15:0]          col;
	logic [15:0]          rb;
	logic [15:0]          rl;
	phase_t               eff_phase;
	logic [15:0]          col_inc;
	logic [ENTRY_W-1:0]   ec_inc;
	logic [15:0]          height_m1;
	logic [31:0]          row_base_prod;
	result_t              res;
	logic                 res_valid;
	logic                 in_acc;

	assign byte_in.ready = !out_valid_q || result_out.ready;
	assign in_acc        = byte_in.valid && byte_in.ready;

	assign height_m1     = height_q - 16'd1;
	assign row_base_prod = height_m1 * width_q;

	always_comb begin
		ph = phase_q;
		hc = header_count_q;
		wd = width_q;
		ht = height_q;
		ec = entry_count_q;
		cc = channel_q;
		bh = blue_hold_q;
		gh = green_hold_q;
		col = column_q;
		rb = row_base_q;
		rl = rows_left_q;
		if (byte_in.start_of_file) begin
			ph = PH_SIG;
			hc = '0;
			wd = '0;
			ht = '0;
			ec = '0;
			cc = '0;
			bh = '0;
			gh = '0;
			col = '0;
			rb = '0;
			rl = '0;
		end
		eff_phase = ph;
		col_inc = col + 16'd1;
		ec_inc = ec + ENTRY_W'(1);
		res = '0;
		res_valid = 1'b0;
		unique case (eff_phase)
			PH_SIG: begin
				if (byte_in.byte_value != ((hc == 6'd0) ? SIG_FIRST : SIG_SECOND)) begin
					res.kind = KIND_BAD_SIG;
					res_valid = 1'b1;
					ph = PH_IDLE;
				end else if (hc == 6'd0) begin
					hc = 6'd1;
				end else begin
					hc = 6'd0;
					ph = PH_HDR;
				end
			end
			PH_HDR: begin
				if (hc == HDR_WIDTH_LO) begin
					wd = {wd[15:8], byte_in.byte_value};
				end else if (hc == HDR_WIDTH_HI) begin
					wd = {byte_in.byte_value, wd[7:0]};
				end else if (hc == HDR_HEIGHT_LO) begin
					ht = {ht[15:8], byte_in.byte_value};
				end else if (hc == HDR_HEIGHT_HI) begin
					ht = {byte_in.byte_value, ht[7:0]};
				end
				if (hc >= HDR_LAST) begin
					res.kind = KIND_HEADER;
					res.image_width = wd;
					res.image_height = ht;
					res_valid = 1'b1;
					hc = 6'd0;
					ec = '0;
					cc = '0;
					ph = PH_PAL;
				end else begin
					hc = hc + 6'd1;
				end
			end
			PH_PAL: begin
				case (cc)
					CH_BLUE: bh = byte_in.byte_value[7:2];
					CH_GREEN: gh = byte_in.byte_value[7:2];
					CH_RED: begin
						if (palette_enable_q) begin
							res.kind = KIND_PALETTE;
							res.palette_index = 8'(ec);
							res.red_level = byte_in.byte_value[7:2];
							res.green_level = gh;
							res.blue_level = bh;
							res_valid = 1'b1;
						end
					end
					CH_RESERVED: begin
						ec = ec_inc;
						if (32'(ec_inc) >= 32'(PALETTE_ENTRIES)) begin
							if (width_q == 16'd0 || height_q == 16'd0) begin
								ph = PH_IDLE;
							end else begin
								col = 16'd0;
								rl = height_q;
								rb = row_base_prod[15:0];
								ph = PH_PIX;
							end
						end
					end
					default: ;
				endcase
				cc = cc + 2'd1;
			end
			PH_PIX: begin
				res.kind = KIND_PIXEL;
				res.pixel_address = rb + col;
				res.pixel_value = byte_in.byte_value;
				res_valid = 1'b1;
				col = col_inc;
				if (col_inc >= wd) begin
					col = 16'd0;
					rb = rb - wd;
					rl = rl - 16'd1;
					if (rl == 16'd0) begin
						res.last = 1'b1;
						ph = PH_IDLE;
					end
				end
			end
			PH_IDLE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SIG;
			header_count_q <= '0;
			width_q <= '0;
			height_q <= '0;
			entry_count_q <= '0;
			channel_q <= '0;
			blue_hold_q <= '0;
			green_hold_q <= '0;
			column_q <= '0;
			row_base_q <= '0;
			rows_left_q <= '0;
			palette_enable_q <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				palette_enable_q <= cfg_wdata;
			end
			if (in_acc) begin
				phase_q <= ph;
				header_count_q <= hc;
				width_q <= wd;
				height_q <= ht;
				entry_count_q <= ec;
				channel_q <= cc;
				blue_hold_q <= bh;
				green_hold_q <= gh;
				column_q <= col;
				row_base_q <= rb;
				rows_left_q <= rl;
				out_valid_q <= res_valid;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_q <= res;
		end
	end

	assign result_out.valid         = out_valid_q;
	assign result_out.kind          = res_q.kind;
	assign result_out.image_width   = res_q.image_width;
	assign result_out.image_height  = res_q.image_height;
	assign result_out.palette_index = res_q.palette_index;
	assign result_out.red_level     = res_q.red_level;
	assign result_out.green_level   = res_q.green_level;
	assign result_out.blue_level    = res_q.blue_level;
	assign result_out.pixel_address = res_q.pixel_address;
	assign result_out.pixel_value   = res_q.pixel_value;
	assign result_out.last          = res_q.last;

	`BMP8_ASSERT_NOW(a_stall_blocks_input, out_valid_q && !result_out.ready, !byte_in.ready, "input taken while result stalled")
	`BMP8_ASSERT_NOW(a_bad_sig_phase, in_acc && res_valid && res.kind == KIND_BAD_SIG, eff_phase == PH_SIG, "bad signature outside signature phase")
	`BMP8_ASSERT_NEXT(a_last_goes_idle, in_acc && res_valid && res.kind == KIND_PIXEL && res.last, phase_q == PH_IDLE, "parser not idle after final pixel")

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the 8-bit palettised bitmap stream parser.
`timescale 1ns / 1ps

module testbench;
	import bmp8_pkg::*;

	localparam int PALETTE_ENTRIES = 256;
	localparam int FILE_BODY = 54 + 4 * PALETTE_ENTRIES;
	localparam int ITEM_TARGET = 1200;
	localparam int SETTLE_CYCLES = 4;
	localparam int WATCHDOG_LIMIT = 1000;

	typedef struct packed {
		logic [7:0] value;
		logic       sof;
	} file_byte_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	bmp8_in_if  byte_in_if ();
	bmp8_out_if result_if ();

	bmp_8bit_stream_parser_top #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.byte_in   (byte_in_if),
		.result_out(result_if)
	);

	always #1 clk = ~clk;

	file_byte_t pending_bytes[$];
	result_t    expected_results[$];

	// Decoder state mirrored from the block.
	phase_t      parse_phase;
	logic [5:0]  hdr_count;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [8:0]  entry_count;
	logic [1:0]  channel;
	logic [5:0]  blue_q;
	logic [5:0]  green_q;
	logic [15:0] column_q;
	logic [15:0] row_base_q;
	logic [15:0] rows_left_q;
	bit          palette_on;

	bit quiet;
	int n_fail;
	int n_queued;
	int n_accepted;
	int n_files;
	int n_cfg;
	int n_header;
	int n_palette;
	int n_pixel;
	int n_bad_sig;
	int idle_cycles;
	int gap_left;
	int stall_left;

	task automatic clear_parse();
		parse_phase = PH_SIG;
		hdr_count   = '0;
		width_q     = '0;
		height_q    = '0;
		entry_count = '0;
		channel     = '0;
		blue_q      = '0;
		green_q     = '0;
		column_q    = '0;
		row_base_q  = '0;
		rows_left_q = '0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic sof);
		result_t     r;
		logic [7:0]  want;
		logic [31:0] prod;
		r = '0;
		if (sof) begin
			clear_parse();
		end
		case (parse_phase)
			PH_SIG: begin
				want = (hdr_count == 6'd0) ? SIG_FIRST : SIG_SECOND;
				if (b != want) begin
					r.kind = KIND_BAD_SIG;
					parse_phase = PH_IDLE;
					expected_results.push_back(r);
				end else if (hdr_count == 6'd0) begin
					hdr_count = 6'd1;
				end else begin
					hdr_count = 6'd0;
					parse_phase = PH_HDR;
				end
			end
			PH_HDR: begin
				case (hdr_count)
					HDR_WIDTH_LO:  width_q[7:0]   = b;
					HDR_WIDTH_HI:  width_q[15:8]  = b;
					HDR_HEIGHT_LO: height_q[7:0]  = b;
					HDR_HEIGHT_HI: height_q[15:8] = b;
					default: ;
				endcase
				if (hdr_count >= HDR_LAST) begin
					r.kind = KIND_HEADER;
					r.image_width = width_q;
					r.image_height = height_q;
					expected_results.push_back(r);
					hdr_count = '0;
					entry_count = '0;
					channel = '0;
					parse_phase = PH_PAL;
				end else begin
					hdr_count = hdr_count + 6'd1;
				end
			end
			PH_PAL: begin
				case (channel)
					CH_BLUE:  blue_q = b[7:2];
					CH_GREEN: green_q = b[7:2];
					CH_RED: begin
						if (palette_on) begin
							r.kind = KIND_PALETTE;
							r.palette_index = entry_count[7:0];
							r.red_level = b[7:2];
							r.green_level = green_q;
							r.blue_level = blue_q;
							expected_results.push_back(r);
						end
					end
					default: begin
						entry_count = entry_count + 9'd1;
						if (entry_count >= PALETTE_ENTRIES) begin
							if (width_q == 16'd0 || height_q == 16'd0) begin
								parse_phase = PH_IDLE;
							end else begin
								column_q = '0;
								rows_left_q = height_q;
								prod = (32'(height_q) - 32'd1) * 32'(width_q);
								row_base_q = prod[15:0];
								parse_phase = PH_PIX;
							end
						end
					end
				endcase
				channel = channel + 2'd1;
			end
			PH_PIX: begin
				r.kind = KIND_PIXEL;
				r.pixel_address = row_base_q + column_q;
				r.pixel_value = b;
				column_q = column_q + 16'd1;
				if (column_q >= width_q) begin
					column_q = '0;
					row_base_q = row_base_q - width_q;
					rows_left_q = rows_left_q - 16'd1;
					if (rows_left_q == 16'd0) begin
						r.last = 1'b1;
						parse_phase = PH_IDLE;
					end
				end
				expected_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			n_fail++;
		end
	endfunction

	task automatic push_byte(input logic [7:0] v, input logic sof);
		pending_bytes.push_back('{v, sof});
		n_queued++;
	endtask

	task automatic queue_file(input logic [15:0] w, input logic [15:0] h, input int n_bytes);
		logic [7:0] v;
		for (int k = 0; k < n_bytes; k++) begin
			case (k)
				0:  v = SIG_FIRST;
				1:  v = SIG_SECOND;
				18: v = w[7:0];
				19: v = w[15:8];
				22: v = h[7:0];
				23: v = h[15:8];
				default: v = 8'($urandom);
			endcase
			push_byte(v, k == 0);
		end
	endtask

	task automatic queue_whole_file(input logic [15:0] w, input logic [15:0] h);
		queue_file(w, h, FILE_BODY + int'(w) * int'(h) + int'($urandom_range(0, 3)));
		n_files++;
	endtask

	task automatic wait_idle();
		do begin
			@(negedge clk);
		end while (pending_bytes.size() != 0 || byte_in_if.valid || expected_results.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_palette_enable(input bit v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		palette_on = v;
		n_cfg++;
	endtask

	// Byte driver: beats come from the pending queue, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in_if.valid <= 1'b0;
			byte_in_if.byte_value <= '0;
			byte_in_if.start_of_file <= 1'b0;
			gap_left = 0;
		end else begin
			if (byte_in_if.valid && byte_in_if.ready) begin
				decode_byte(byte_in_if.byte_value, byte_in_if.start_of_file);
				n_accepted++;
			end
			if (!byte_in_if.valid || byte_in_if.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					byte_in_if.valid <= 1'b0;
				end else if (pending_bytes.size() == 0) begin
					byte_in_if.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 7) == 0) begin
					gap_left = $urandom_range(0, 2);
					byte_in_if.valid <= 1'b0;
				end else begin
					byte_in_if.valid <= 1'b1;
					byte_in_if.byte_value <= pending_bytes[0].value;
					byte_in_if.start_of_file <= pending_bytes[0].sof;
					pending_bytes.pop_front();
				end
			end
		end
	end

	// Result monitor: every beat taken is checked against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat of kind %0d with no expectation", result_if.kind);
					n_fail++;
				end else begin
					e = expected_results.pop_front();
					check_field("kind", e.kind, result_if.kind);
					check_field("image_width", e.image_width, result_if.image_width);
					check_field("image_height", e.image_height, result_if.image_height);
					check_field("palette_index", e.palette_index, result_if.palette_index);
					check_field("red_level", e.red_level, result_if.red_level);
					check_field("green_level", e.green_level, result_if.green_level);
					check_field("blue_level", e.blue_level, result_if.blue_level);
					check_field("pixel_address", e.pixel_address, result_if.pixel_address);
					check_field("pixel_value", e.pixel_value, result_if.pixel_value);
					check_field("last", e.last, result_if.last);
					case (e.kind)
						KIND_HEADER:  n_header++;
						KIND_PALETTE: n_palette++;
						KIND_PIXEL:   n_pixel++;
						default:      n_bad_sig++;
					endcase
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 2);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_in_if.valid && byte_in_if.ready) || (result_if.valid && result_if.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int unsigned w;
		int unsigned h;
		int unsigned pick;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		byte_in_if.valid = 1'b0;
		byte_in_if.byte_value = '0;
		byte_in_if.start_of_file = 1'b0;
		result_if.ready = 1'b0;
		palette_on = 1'b1;
		clear_parse();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_palette_enable(1'b1);

		// Signature accepted without a start mark, then a restart on a bad first byte.
		push_byte(SIG_FIRST, 1'b0);
		push_byte(SIG_SECOND, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(SIG_FIRST, 1'b0);
		// Bad second byte, and a second signature byte seen first.
		push_byte(SIG_FIRST, 1'b1);
		push_byte(8'hFF, 1'b0);
		push_byte(SIG_SECOND, 1'b1);
		push_byte(SIG_FIRST, 1'b1);
		push_byte(SIG_SECOND, 1'b0);
		push_byte(8'h55, 1'b0);
		push_byte(SIG_SECOND, 1'b1);
		push_byte(8'hAA, 1'b1);
		push_byte(SIG_FIRST, 1'b1);
		push_byte(SIG_FIRST, 1'b0);

		// A header and a few palette entries that are skipped.
		set_palette_enable(1'b0);
		w = $urandom_range(0, 65535);
		h = $urandom_range(0, 65535);
		queue_file(w[15:0], h[15:0], 54 + 4 * 3);

		while (n_queued < ITEM_TARGET - FILE_BODY - 20) begin
			if ($urandom_range(0, 3) == 0) begin
				set_palette_enable(1'($urandom_range(0, 1)));
			end
			pick = $urandom_range(0, 1);
			if (pick == 0) begin
				w = $urandom_range(0, 65535);
				h = $urandom_range(0, 65535);
				queue_file(w[15:0], h[15:0], int'($urandom_range(1, 12)));
			end else begin
				repeat ($urandom_range(4, 12)) begin
					push_byte(8'($urandom), $urandom_range(0, 5) == 0);
				end
			end
		end

		set_palette_enable(1'b1);
		w = $urandom_range(1, 6);
		h = $urandom_range(2, 6);
		queue_whole_file(w[15:0], h[15:0]);

		wait_idle();
		quiet = 1'b1;
		w = $urandom_range(0, 65535);
		h = $urandom_range(0, 65535);
		queue_file(w[15:0], h[15:0], int'($urandom_range(24, 40)));

		wait_idle();
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d expected results never arrived", expected_results.size());
			n_fail++;
		end
		$display("Run covered %0d bytes, %0d complete files and %0d register writes.",
			n_accepted, n_files, n_cfg);
		$display("Checked %0d headers, %0d palette entries, %0d pixels, %0d bad signatures.",
			n_header, n_palette, n_pixel, n_bad_sig);
		if (n_fail == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
